### design/baro_pkg.sv
// Shared constants and types for the barometer compensation core.
`timescale 1ns / 1ps
package baro_pkg;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int RAW_W      = 20;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_T1  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_T2  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_T3  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_P1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_P23 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_P45 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_P67 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_P89 = 3'd7;

    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] RAW_FULL    = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE = 64'd3125;
    localparam logic [63:0] ROUND_HALF  = 64'd128;

    // divider control/status
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;
endpackage

### design/baro_mul.sv
// Shared 64x64 wrapping multiplier built from 32x32 partial products over cycles.
`timescale 1ns / 1ps
module baro_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] prod
);
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [63:0] a_reg, b_reg, acc_reg, acc_next;
    logic [31:0] mx, my;
    logic [63:0] pp;
    logic        done_reg, done_next;

    // pick partial product: lo*lo, lo*hi, hi*lo
    always_comb begin
        case (step_reg)
            2'd0:    begin mx = a_reg[31:0];  my = b_reg[31:0];  end
            2'd1:    begin mx = a_reg[31:0];  my = b_reg[63:32]; end
            default: begin mx = a_reg[63:32]; my = b_reg[31:0];  end
        endcase
    end
    assign pp = {32'd0, mx} * {32'd0, my};

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            step_next = 2'd0;
            acc_next  = 64'd0;
        end else if (busy_reg) begin
            if (step_reg == 2'd0) begin
                acc_next = pp;
            end else begin
                acc_next = acc_reg + {pp[31:0], 32'd0};
            end
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd2) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
        if (start) begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

### design/baro_div.sv
// Radix-2 restoring signed 64-bit divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module baro_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  baro_pkg::div_req_t req,
    output baro_pkg::div_rsp_t rsp
);
    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] rem_reg, quo_reg, den_reg;
    logic        neg_reg, done_reg;
    logic [64:0] trial;
    logic [64:0] shifted;

    assign shifted = {rem_reg, quo_reg[63]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd64) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (req.start) begin
            // magnitudes and result sign
            rem_reg <= 64'd0;
            quo_reg <= req.num[63] ? (64'd0 - req.num) : req.num;
            den_reg <= req.den[63] ? (64'd0 - req.den) : req.den;
            neg_reg <= req.num[63] ^ req.den[63];
        end else if (busy_reg) begin
            if (cnt_reg == 7'd64) begin
                if (neg_reg) quo_reg <= 64'd0 - quo_reg;
            end else if (!trial[64]) begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rem_reg <= shifted[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

### design/barometer_raw_to_calibrated_core.sv
// Top level: calibration registers, sequencer, shared multiplier and divider.
// Temperature item: four multiplies and 4 steps from accept to m_tvalid.
// Pressure item: ten multiplies, one divide and 6 steps; on a zero divisor it ends after six multiplies.
// One item at a time; s_tready is low while an item is at work or its result waits, so the
// next transaction is accepted only after the previous result has been taken on m_tready.
// Reset (aresetn low, synchronous) clears calibration registers, fine temperature, sequencer state and m_tvalid.
`timescale 1ns / 1ps
module barometer_raw_to_calibrated_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [19:0] raw_sample
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] temperature_centi, [47:16] pressure_q24_8
    output logic [1:0]  m_tuser,   // [0] result_kind, [1] invalid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [baro_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [baro_pkg::CFG_DATA_W-1:0] cfg_data
);
    // sequencer states
    localparam logic [5:0] S_IDLE = 6'd0;
    localparam logic [5:0] S_T0 = 6'd1,  S_T1 = 6'd2,  S_T2 = 6'd3,  S_T3 = 6'd4;
    localparam logic [5:0] S_T4 = 6'd5,  S_T5 = 6'd6,  S_T6 = 6'd7;
    localparam logic [5:0] S_P0 = 6'd8,  S_P1 = 6'd9,  S_P2 = 6'd10, S_P3 = 6'd11;
    localparam logic [5:0] S_P4 = 6'd12, S_P5 = 6'd13, S_P6 = 6'd14, S_P7 = 6'd15;
    localparam logic [5:0] S_P8 = 6'd16;
    localparam logic [5:0] S_P16 = 6'd24, S_DIV = 6'd25, S_P17 = 6'd26, S_P18 = 6'd27;
    localparam logic [5:0] S_P19 = 6'd28, S_P20 = 6'd29, S_P21 = 6'd30, S_OUT = 6'd31;

    logic [15:0] t1_reg, t2_reg, t3_reg, p1_reg;
    logic [31:0] p23_reg, p45_reg, p67_reg, p89_reg;
    logic [31:0] fine_reg;

    logic [5:0]  state_reg;
    logic        wait_reg;        // multiply in flight
    logic        kind_reg;
    logic [baro_pkg::RAW_W-1:0] raw_reg;
    logic [63:0] ra_reg, rb_reg, rc_reg, rd_reg;
    logic        mstart;
    logic [63:0] ma, mb, prod;
    logic        mdone;
    baro_pkg::div_req_t dreq;
    baro_pkg::div_rsp_t drsp;
    logic        mval_reg;
    logic [15:0] tout_reg;
    logic [31:0] pout_reg;
    logic        inv_reg;
    logic [63:0] press_diff;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        sx16 = {{48{v[15]}}, v};
    endfunction
    function automatic logic [63:0] sx32(input logic [31:0] v);
        sx32 = {{32{v[31]}}, v};
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE) && !mval_reg;

    // full-scale minus raw reading
    assign press_diff = baro_pkg::RAW_FULL - {44'd0, raw_reg};

    // calibration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg <= 16'd0; t2_reg <= 16'd0; t3_reg <= 16'd0; p1_reg <= 16'd0;
            p23_reg <= 32'd0; p45_reg <= 32'd0; p67_reg <= 32'd0; p89_reg <= 32'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                baro_pkg::REG_T1:  t1_reg  <= cfg_data[15:0];
                baro_pkg::REG_T2:  t2_reg  <= cfg_data[15:0];
                baro_pkg::REG_T3:  t3_reg  <= cfg_data[15:0];
                baro_pkg::REG_P1:  p1_reg  <= cfg_data[15:0];
                baro_pkg::REG_P23: p23_reg <= cfg_data;
                baro_pkg::REG_P45: p45_reg <= cfg_data;
                baro_pkg::REG_P67: p67_reg <= cfg_data;
                baro_pkg::REG_P89: p89_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    baro_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mstart),
        .op_a(ma), .op_b(mb), .done(mdone), .prod(prod)
    );
    baro_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // multiply operands per step; a multiply starts on entry (wait_reg low)
    always_comb begin
        ma = ra_reg;
        mb = rb_reg;
        case (state_reg)
            S_T0:  begin ma = ra_reg; mb = sx16(t2_reg); end
            S_T1:  begin ma = rb_reg; mb = rb_reg; end
            S_T2:  begin ma = rc_reg; mb = sx16(t3_reg); end
            S_T4:  begin ma = sx32(fine_reg); mb = 64'd5; end
            S_P0:  begin ma = ra_reg; mb = ra_reg; end
            S_P1:  begin ma = rb_reg; mb = sx16(p67_reg[15:0]); end
            S_P2:  begin ma = ra_reg; mb = sx16(p45_reg[31:16]); end
            S_P3:  begin ma = rb_reg; mb = sx16(p23_reg[31:16]); end
            S_P4:  begin ma = ra_reg; mb = sx16(p23_reg[15:0]); end
            S_P5:  begin ma = rb_reg; mb = {48'd0, p1_reg}; end
            S_P7:  begin ma = rd_reg; mb = baro_pkg::PRESS_SCALE; end
            S_P17: begin ma = rb_reg; mb = rb_reg; end
            S_P18: begin ma = rb_reg; mb = sx16(p89_reg[31:16]); end
            S_P19: begin ma = ra_reg; mb = sx16(p89_reg[15:0]); end
            default: ;
        endcase
    end

    always_comb begin
        mstart = 1'b0;
        case (state_reg)
            S_T0, S_T1, S_T2, S_T4, S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P7,
            S_P17, S_P18, S_P19: mstart = !wait_reg;
            default: mstart = 1'b0;
        endcase
    end

    always_comb begin
        dreq.start = (state_reg == S_P16);
        dreq.num   = rd_reg;
        dreq.den   = rc_reg;
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
            mval_reg  <= 1'b0;
            fine_reg  <= 32'd0;
        end else begin
            if (mval_reg && m_tready) mval_reg <= 1'b0;
            if (mdone)       wait_reg <= 1'b0;
            else if (mstart) wait_reg <= 1'b1;
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        kind_reg <= s_tuser;
                        raw_reg  <= s_tdata[19:0];
                        if (!s_tuser) begin
                            // d1 = (adc>>3) - 2*T1, d2 = (adc>>4) - T1
                            ra_reg <= sx32(32'({15'd0, s_tdata[19:3]}
                                      - {15'd0, t1_reg, 1'b0}));
                            rb_reg <= sx32(32'({16'd0, s_tdata[19:4]} - {16'd0, t1_reg}));
                            state_reg <= S_T0;
                        end else begin
                            ra_reg <= sx32(fine_reg) - baro_pkg::FINE_OFFSET;
                            state_reg <= S_P0;
                        end
                    end
                end
                S_T0: if (mdone) begin
                    rd_reg <= sx32({{11{prod[31]}}, prod[31:11]});
                    state_reg <= S_T1;
                end
                S_T1: if (mdone) begin
                    rc_reg <= sx32({{12{prod[31]}}, prod[31:12]});
                    state_reg <= S_T2;
                end
                S_T2: if (mdone) begin
                    rc_reg <= sx32({{14{prod[31]}}, prod[31:14]});
                    state_reg <= S_T3;
                end
                S_T3: begin
                    fine_reg  <= rd_reg[31:0] + rc_reg[31:0];
                    state_reg <= S_T4;
                end
                S_T4: if (mdone) begin
                    rc_reg <= prod + baro_pkg::ROUND_HALF;
                    state_reg <= S_T5;
                end
                S_T5: begin
                    rc_reg <= {{8{rc_reg[63]}}, rc_reg[63:8]};
                    state_reg <= S_T6;
                end
                S_T6: begin
                    // saturate to 16 bits signed
                    if (rc_reg[63] && !(&rc_reg[62:15])) tout_reg <= 16'h8000;
                    else if (!rc_reg[63] && (|rc_reg[62:15])) tout_reg <= 16'h7FFF;
                    else tout_reg <= rc_reg[15:0];
                    pout_reg <= 32'd0;
                    inv_reg  <= 1'b0;
                    state_reg <= S_OUT;
                end
                S_P0: if (mdone) begin rb_reg <= prod; state_reg <= S_P1; end
                S_P1: if (mdone) begin rc_reg <= prod; state_reg <= S_P2; end
                S_P2: if (mdone) begin
                    rc_reg <= rc_reg + {prod[46:0], 17'd0}
                              + {{13{p45_reg[15]}}, p45_reg[15:0], 35'd0};
                    state_reg <= S_P3;
                end
                S_P3: if (mdone) begin
                    rd_reg <= {{8{prod[63]}}, prod[63:8]};
                    state_reg <= S_P4;
                end
                S_P4: if (mdone) begin
                    rb_reg <= (64'd1 << 47) + rd_reg + {prod[51:0], 12'd0};
                    state_reg <= S_P5;
                end
                S_P5: if (mdone) begin
                    rb_reg <= {{33{prod[63]}}, prod[63:33]};
                    state_reg <= S_P6;
                end
                S_P6: begin
                    if (rb_reg == 64'd0) begin
                        tout_reg <= 16'd0; pout_reg <= 32'd0; inv_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        rd_reg <= {press_diff[32:0], 31'd0} - rc_reg;
                        rc_reg <= rb_reg;
                        state_reg <= S_P7;
                    end
                end
                S_P7: if (mdone) begin rd_reg <= prod; state_reg <= S_P16; end
                S_P16: state_reg <= S_DIV;
                S_DIV: if (drsp.done) begin
                    ra_reg <= drsp.quo;
                    rb_reg <= {{13{drsp.quo[63]}}, drsp.quo[63:13]};
                    state_reg <= S_P17;
                end
                S_P17: if (mdone) begin rb_reg <= prod; state_reg <= S_P18; end
                S_P18: if (mdone) begin
                    rc_reg <= {{25{prod[63]}}, prod[63:25]};
                    state_reg <= S_P19;
                end
                S_P19: if (mdone) begin
                    rd_reg <= {{19{prod[63]}}, prod[63:19]};
                    state_reg <= S_P20;
                end
                S_P20: begin
                    ra_reg <= ra_reg + rc_reg + rd_reg;
                    state_reg <= S_P21;
                end
                S_P21: begin
                    rb_reg <= {{8{ra_reg[63]}}, ra_reg[63:8]}
                              + {{44{p67_reg[31]}}, p67_reg[31:16], 4'd0};
                    state_reg <= S_P8;
                end
                S_P8: begin
                    tout_reg <= 16'd0;
                    inv_reg  <= 1'b0;
                    if (rb_reg[63]) pout_reg <= 32'd0;
                    else if (|rb_reg[62:32]) pout_reg <= 32'hFFFFFFFF;
                    else pout_reg <= rb_reg[31:0];
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    mval_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = {pout_reg, tout_reg};
    assign m_tuser  = {inv_reg, kind_reg};
endmodule
